FILE: hw/rtl/bhvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhvm_pkg
// Shared widths, command codes and controller state codes for the buffer
// handle and address map table.
// ----------------------------------------------------------------------------
package bhvm_pkg;

	localparam int CMD_W        = 3;
	localparam int HANDLE_IN_W  = 8;
	localparam int SIZE_W       = 48;
	localparam int ADDR_W       = 48;
	localparam int SEQ_W        = 48;
	localparam int RES_HANDLE_W = 5;

	localparam logic [SEQ_W-1:0] SEQ_LAST = {SEQ_W{1'b1}};

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE  = 3'd0,
		CMD_DESTROY = 3'd1,
		CMD_MAP     = 3'd2,
		CMD_LOOKUP  = 3'd3,
		CMD_SUBMIT  = 3'd4,
		CMD_WAIT    = 3'd5
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_WALK = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

endpackage

FILE: hw/rtl/bhvm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhvm_req_if
// Request channel: one command with its operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bhvm_req_if;
	import bhvm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       cmd;
	logic [HANDLE_IN_W-1:0] buffer_handle;
	logic [SIZE_W-1:0]      buffer_size;
	logic [ADDR_W-1:0]      virt_addr;
	logic [SEQ_W-1:0]       wait_seq;

	modport source (
		output valid, cmd, buffer_handle, buffer_size, virt_addr, wait_seq,
		input  ready
	);

	modport sink (
		input  valid, cmd, buffer_handle, buffer_size, virt_addr, wait_seq,
		output ready
	);

endinterface

FILE: hw/rtl/bhvm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhvm_rsp_if
// Result channel: status, handle and sequence number, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bhvm_rsp_if;
	import bhvm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    ok;
	logic [RES_HANDLE_W-1:0] result_handle;
	logic [SEQ_W-1:0]        result_seq;

	modport source (
		output valid, ok, result_handle, result_seq,
		input  ready
	);

	modport sink (
		input  valid, ok, result_handle, result_seq,
		output ready
	);

endinterface

FILE: hw/rtl/buffer_handle_va_map_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_handle_va_map_table
// Buffer handle allocator with an address map memory and a job sequence
// counter; one result for every request.
// ----------------------------------------------------------------------------
// Usage:
//  - req carries one command (create, destroy, map, lookup, submit, wait) and
//    its operands; rsp returns ok, result_handle and result_seq for it.
//  - requests are processed one at a time. create, map, submit, wait and
//    unused codes go from the execute state straight to the response state.
//  - lookup and destroy walk the map memory, one entry per cycle through its
//    single registered read port; lookup stops at its first hit.
//  - a new request is taken the cycle after the output register loads.
//  - destroy detaches matching entries by writing them back behind the read
//    pointer, so no entry is read after it has been rewritten.
//  - the result sits in an output register; the next request is taken while
//    it waits. A stalled receiver holds the block only once a second result
//    is ready and the register is still full.
//  - reset clears all handles, the map count and the sequence counters at
//    once; the map memory holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module buffer_handle_va_map_table #(
	parameter int BUFFER_SLOTS = 32,
	parameter int MAP_SLOTS    = 32
) (
	input  logic clk,
	input  logic arst_n,
	bhvm_req_if.sink   req,
	bhvm_rsp_if.source rsp
);
	import bhvm_pkg::*;

	localparam int HW  = $clog2(BUFFER_SLOTS);
	localparam int NHW = $clog2(BUFFER_SLOTS + 1);
	localparam int MIW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
	localparam int MCW = $clog2(MAP_SLOTS + 1);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [HW-1:0]     handle;
	} map_entry_t;

	// control state
	state_t                  state_q;
	logic [BUFFER_SLOTS-1:0] slot_live_q;
	logic [NHW-1:0]          next_handle_q;
	logic [MCW-1:0]          map_count_q;
	logic [SEQ_W-1:0]        next_seq_q;
	logic [SEQ_W-1:0]        done_seq_q;
	logic [MCW-1:0]          rd_idx_q;
	logic                    pend_s1;
	logic                    out_valid_q;

	// latched request
	logic [CMD_W-1:0]       cmd_q;
	logic [HANDLE_IN_W-1:0] handle_q;
	logic [SIZE_W-1:0]      size_q;
	logic [ADDR_W-1:0]      va_q;
	logic [SEQ_W-1:0]       wait_seq_q;

	// result and output registers
	logic                    res_ok_q;
	logic [RES_HANDLE_W-1:0] res_handle_q;
	logic [SEQ_W-1:0]        res_seq_q;
	logic                    out_ok_q;
	logic [RES_HANDLE_W-1:0] out_handle_q;
	logic [SEQ_W-1:0]        out_seq_q;

	// map memory
	map_entry_t map_mem [MAP_SLOTS];
	map_entry_t rd_data_s1;
	logic [MIW-1:0] idx_s1;

	logic       mem_rd_en;
	logic       mem_wr_en;
	logic [MIW-1:0] mem_wr_idx;
	map_entry_t mem_wr_data;

	logic                    live;
	logic                    create_room;
	logic                    map_room;
	logic                    seq_room;
	logic                    is_lookup;
	logic                    walk_issue;
	logic                    walk_hit;
	logic                    walk_end;
	logic                    resp_load;
	logic                    ex_ok;
	logic [RES_HANDLE_W-1:0] ex_handle;
	logic [SEQ_W-1:0]        ex_seq;

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.ok            = out_ok_q;
	assign rsp.result_handle = out_handle_q;
	assign rsp.result_seq    = out_seq_q;

	always_comb begin
		live = (handle_q != '0)
			&& ({1'b0, handle_q} < (HANDLE_IN_W + 1)'(BUFFER_SLOTS))
			&& slot_live_q[handle_q[HW-1:0]];
		create_room = next_handle_q < NHW'(BUFFER_SLOTS);
		map_room    = map_count_q < MCW'(MAP_SLOTS);
		seq_room    = next_seq_q != SEQ_LAST;
		is_lookup   = (cmd_q == CMD_LOOKUP);
		walk_issue  = (state_q == ST_WALK) && (rd_idx_q < map_count_q);
		if (is_lookup) begin
			walk_hit = pend_s1 && (rd_data_s1.addr == va_q) && (rd_data_s1.handle != '0);
		end else begin
			walk_hit = pend_s1 && (rd_data_s1.handle == handle_q[HW-1:0]);
		end
		walk_end  = (is_lookup && walk_hit) || (!walk_issue && !pend_s1);
		resp_load = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);
		mem_rd_en = walk_issue;

		ex_ok     = 1'b0;
		ex_handle = '0;
		ex_seq    = '0;
		unique case (cmd_q)
			CMD_CREATE: begin
				ex_ok     = create_room;
				ex_handle = create_room ? RES_HANDLE_W'(next_handle_q) : '0;
			end
			CMD_DESTROY: ex_ok = live;
			CMD_MAP:     ex_ok = live && map_room;
			CMD_LOOKUP:  ex_ok = 1'b0;
			CMD_SUBMIT: begin
				ex_ok  = live && seq_room;
				ex_seq = (live && seq_room) ? next_seq_q : '0;
			end
			CMD_WAIT:    ex_ok = (done_seq_q >= wait_seq_q);
			default:     ex_ok = 1'b0;
		endcase

		// append on map, detach behind the read pointer on destroy
		mem_wr_en   = 1'b0;
		mem_wr_idx  = map_count_q[MIW-1:0];
		mem_wr_data = '{addr: va_q, handle: handle_q[HW-1:0]};
		if (state_q == ST_EXEC && cmd_q == CMD_MAP && live && map_room) begin
			mem_wr_en = 1'b1;
		end else if (state_q == ST_WALK && !is_lookup && walk_hit) begin
			mem_wr_en   = 1'b1;
			mem_wr_idx  = idx_s1;
			mem_wr_data = '{addr: rd_data_s1.addr, handle: '0};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr_en) begin
			map_mem[mem_wr_idx] <= mem_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_rd_en) begin
			rd_data_s1 <= map_mem[rd_idx_q[MIW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			slot_live_q   <= '0;
			next_handle_q <= NHW'(1);
			map_count_q   <= '0;
			next_seq_q    <= SEQ_W'(1);
			done_seq_q    <= '0;
			rd_idx_q      <= '0;
			pend_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rd_idx_q <= '0;
					pend_s1  <= 1'b0;
					state_q  <= ST_RESP;
					case (cmd_q)
						CMD_CREATE: begin
							if (create_room) begin
								slot_live_q[next_handle_q[HW-1:0]] <= (size_q != '0);
								next_handle_q <= next_handle_q + NHW'(1);
							end
						end
						CMD_DESTROY: begin
							if (live) begin
								slot_live_q[handle_q[HW-1:0]] <= 1'b0;
								if (map_count_q != '0) begin
									state_q <= ST_WALK;
								end
							end
						end
						CMD_MAP: begin
							if (live && map_room) begin
								map_count_q <= map_count_q + MCW'(1);
							end
						end
						CMD_LOOKUP: begin
							if (map_count_q != '0) begin
								state_q <= ST_WALK;
							end
						end
						CMD_SUBMIT: begin
							if (live && seq_room) begin
								done_seq_q <= next_seq_q;
								next_seq_q <= next_seq_q + SEQ_W'(1);
							end
						end
						default: begin
						end
					endcase
				end
				ST_WALK: begin
					pend_s1 <= walk_issue;
					if (walk_issue) begin
						rd_idx_q <= rd_idx_q + MCW'(1);
					end
					if (walk_end) begin
						pend_s1 <= 1'b0;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (resp_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q      <= req.cmd;
			handle_q   <= req.buffer_handle;
			size_q     <= req.buffer_size;
			va_q       <= req.virt_addr;
			wait_seq_q <= req.wait_seq;
		end
		if (walk_issue) begin
			idx_s1 <= rd_idx_q[MIW-1:0];
		end
		if (state_q == ST_EXEC) begin
			res_ok_q     <= ex_ok;
			res_handle_q <= ex_handle;
			res_seq_q    <= ex_seq;
		end else if (state_q == ST_WALK && is_lookup && walk_hit) begin
			res_ok_q     <= 1'b1;
			res_handle_q <= RES_HANDLE_W'(rd_data_s1.handle);
		end
		if (resp_load) begin
			out_ok_q     <= res_ok_q;
			out_handle_q <= res_handle_q;
			out_seq_q    <= res_seq_q;
		end
	end

	// handle zero is never handed out
	a_slot_zero_dead: assert property (@(posedge clk) disable iff (!arst_n)
		!slot_live_q[0])
		else $error("handle zero marked live");

	a_map_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		map_count_q <= MCW'(MAP_SLOTS))
		else $error("map count beyond table");

	// a detach only rewrites an entry that has already been read
	a_wb_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr_en && state_q == ST_WALK) |-> (MCW'(idx_s1) < rd_idx_q))
		else $error("map write-back ahead of read pointer");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_EXEC))
		else $error("accepted request not executed");

	a_sequence_order: assert property (@(posedge clk) disable iff (!arst_n)
		done_seq_q < next_seq_q)
		else $error("completed sequence not below next sequence");

endmodule
